>>> src/assert_macros.svh
// Assertion helpers for the RTL of the cache; tghc_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A plain invariant that must hold at every rising clock edge outside reset.
`define TGHC_CHECK(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("cache invariant violated");

// An implication checked at every rising clock edge outside reset.
`define TGHC_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cache implication violated");

`endif

>>> src/tghc_pkg.sv
package tghc_pkg;

    localparam int KEY_W   = 21;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 9;
    localparam int OP_W    = 2;

    localparam int DEF_POOL_ENTRIES = 512;
    localparam int DEF_BUCKETS      = 64;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        young_count;
        logic                      full_res;
    } res_t;

endpackage

>>> src/two_generation_hashed_cache.sv
// An accepted lookup or store gets its bucket from tghc_bucket_mod, reads both heads, walks the
// young chain and then the old one; an old hit is moved into the young generation, and a store
// that misses is inserted there if an entry is free. A generation swap frees every old entry.
// One item at a time: s_tready stays low from an accepted item until its result is passed on.
// Reset: synchronous, active low; a clearing pass over max(POOL_ENTRIES, BUCKETS) indices
// (512 by default) follows reset and a clear item, with s_tready low meanwhile.
module two_generation_hashed_cache
    import tghc_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int BUCKETS      = DEF_BUCKETS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[20:0], value[36:21], zero fill
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[15:0], young_count[24:16], full_res[25]
    output logic        m_tuser    // hit[0]
);

    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    res_t res;
    res_t out_reg;
    logic res_valid, res_ready;
    logic m_valid_reg;

    logic                      mod_start, mod_done;
    logic [BW-1:0]             mod_bucket;
    logic [IW-1:0]             e_rd_addr, e_link_addr, e_kv_addr;
    logic [KEY_W-1:0]          e_rd_key, e_wr_key;
    logic signed [VALUE_W-1:0] e_rd_value, e_wr_value;
    logic [LW-1:0]             e_rd_link, e_link_data;
    logic                      e_link_we, e_key_we, e_val_we;
    logic [BW-1:0]             h_rd_addr, h_wr_addr;
    logic [LW-1:0]             h_rd_a, h_rd_b, h_wr_data;
    logic                      h_we_a, h_we_b;

    tghc_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .key(s_tdata[20:0]),
        .done(mod_done), .bucket(mod_bucket)
    );

    tghc_entry_mem #(.POOL_ENTRIES(POOL_ENTRIES)) u_entry (
        .aclk(aclk), .rd_addr(e_rd_addr), .rd_key(e_rd_key), .rd_value(e_rd_value),
        .rd_link(e_rd_link), .link_we(e_link_we), .link_addr(e_link_addr),
        .link_data(e_link_data), .key_we(e_key_we), .val_we(e_val_we),
        .kv_addr(e_kv_addr), .wr_key(e_wr_key), .wr_value(e_wr_value)
    );

    tghc_head_mem #(.POOL_ENTRIES(POOL_ENTRIES), .BUCKETS(BUCKETS)) u_head (
        .aclk(aclk), .rd_addr(h_rd_addr), .rd_a(h_rd_a), .rd_b(h_rd_b),
        .we_a(h_we_a), .we_b(h_we_b), .wr_addr(h_wr_addr), .wr_data(h_wr_data)
    );

    tghc_ctrl #(.POOL_ENTRIES(POOL_ENTRIES), .BUCKETS(BUCKETS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
        .in_key(s_tdata[20:0]), .in_value(s_tdata[36:21]),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .mod_start(mod_start), .mod_done(mod_done), .mod_bucket(mod_bucket),
        .e_rd_addr(e_rd_addr), .e_rd_key(e_rd_key), .e_rd_value(e_rd_value),
        .e_rd_link(e_rd_link), .e_link_we(e_link_we), .e_link_addr(e_link_addr),
        .e_link_data(e_link_data), .e_key_we(e_key_we), .e_val_we(e_val_we),
        .e_kv_addr(e_kv_addr), .e_wr_key(e_wr_key), .e_wr_value(e_wr_value),
        .h_rd_addr(h_rd_addr), .h_rd_a(h_rd_a), .h_rd_b(h_rd_b), .h_we_a(h_we_a),
        .h_we_b(h_we_b), .h_wr_addr(h_wr_addr), .h_wr_data(h_wr_data)
    );

    // The output register lets the controller start the next item while a result waits.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {6'b0, out_reg.full_res, out_reg.young_count, out_reg.read_value};

endmodule

>>> src/tghc_bucket_mod.sv
module tghc_bucket_mod
    import tghc_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BW-1:0]    bucket
);

    // The quotient floor(key * RECIP / 2^SH) equals key / BUCKETS for every key of
    // KEY_W bits, so the remainder follows from one multiply and one subtract.
    localparam int LB = $clog2(BUCKETS);
    localparam int SH = KEY_W + LB;
    localparam int RW = KEY_W + 2;
    localparam int PW = KEY_W + RW;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_64);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] quot_reg, quot_next;
    logic [BW-1:0]    bucket_reg, bucket_next;
    logic             stage_reg;
    logic             done_reg;
    logic [PW-1:0]    prod;
    logic [31:0]      rem;

    assign prod        = PW'(key) * PW'(RECIP);
    assign quot_next   = KEY_W'(prod >> SH);
    assign rem         = 32'(key_reg) - 32'(quot_reg) * 32'(BUCKETS);
    assign bucket_next = BW'(rem);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg  <= key;
            quot_reg <= quot_next;
        end
        if (stage_reg) begin
            bucket_reg <= bucket_next;
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

>>> src/tghc_entry_mem.sv
module tghc_entry_mem
    import tghc_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    localparam int IW = $clog2(POOL_ENTRIES),
    localparam int LW = $clog2(POOL_ENTRIES + 1)
) (
    input  logic                      aclk,
    input  logic [IW-1:0]             rd_addr,
    output logic [KEY_W-1:0]          rd_key,
    output logic signed [VALUE_W-1:0] rd_value,
    output logic [LW-1:0]             rd_link,
    input  logic                      link_we,
    input  logic [IW-1:0]             link_addr,
    input  logic [LW-1:0]             link_data,
    input  logic                      key_we,
    input  logic                      val_we,
    input  logic [IW-1:0]             kv_addr,
    input  logic [KEY_W-1:0]          wr_key,
    input  logic signed [VALUE_W-1:0] wr_value
);

    logic [KEY_W-1:0]          key_mem [POOL_ENTRIES];
    logic signed [VALUE_W-1:0] val_mem [POOL_ENTRIES];
    logic [LW-1:0]             link_mem [POOL_ENTRIES];

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[kv_addr] <= wr_key;
        end
        if (val_we) begin
            val_mem[kv_addr] <= wr_value;
        end
        if (link_we) begin
            link_mem[link_addr] <= link_data;
        end
        rd_key   <= key_mem[rd_addr];
        rd_value <= val_mem[rd_addr];
        rd_link  <= link_mem[rd_addr];
    end

endmodule

>>> src/tghc_head_mem.sv
module tghc_head_mem
    import tghc_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int BUCKETS      = DEF_BUCKETS,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int LW = $clog2(POOL_ENTRIES + 1)
) (
    input  logic          aclk,
    input  logic [BW-1:0] rd_addr,
    output logic [LW-1:0] rd_a,
    output logic [LW-1:0] rd_b,
    input  logic          we_a,
    input  logic          we_b,
    input  logic [BW-1:0] wr_addr,
    input  logic [LW-1:0] wr_data
);

    logic [LW-1:0] head_a [BUCKETS];
    logic [LW-1:0] head_b [BUCKETS];

    always_ff @(posedge aclk) begin
        if (we_a) begin
            head_a[wr_addr] <= wr_data;
        end
        if (we_b) begin
            head_b[wr_addr] <= wr_data;
        end
        rd_a <= head_a[rd_addr];
        rd_b <= head_b[rd_addr];
    end

endmodule

>>> src/tghc_ctrl.sv
`include "assert_macros.svh"

module tghc_ctrl
    import tghc_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int BUCKETS      = DEF_BUCKETS,
    localparam int IW = $clog2(POOL_ENTRIES),
    localparam int LW = $clog2(POOL_ENTRIES + 1),
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           in_op,
    input  logic [KEY_W-1:0]          in_key,
    input  logic signed [VALUE_W-1:0] in_value,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_t                      res,
    output logic                      mod_start,
    input  logic                      mod_done,
    input  logic [BW-1:0]             mod_bucket,
    output logic [IW-1:0]             e_rd_addr,
    input  logic [KEY_W-1:0]          e_rd_key,
    input  logic signed [VALUE_W-1:0] e_rd_value,
    input  logic [LW-1:0]             e_rd_link,
    output logic                      e_link_we,
    output logic [IW-1:0]             e_link_addr,
    output logic [LW-1:0]             e_link_data,
    output logic                      e_key_we,
    output logic                      e_val_we,
    output logic [IW-1:0]             e_kv_addr,
    output logic [KEY_W-1:0]          e_wr_key,
    output logic signed [VALUE_W-1:0] e_wr_value,
    output logic [BW-1:0]             h_rd_addr,
    input  logic [LW-1:0]             h_rd_a,
    input  logic [LW-1:0]             h_rd_b,
    output logic                      h_we_a,
    output logic                      h_we_b,
    output logic [BW-1:0]             h_wr_addr,
    output logic [LW-1:0]             h_wr_data
);

    localparam int HALF_POOL = POOL_ENTRIES / 2;
    localparam int FW        = $clog2(HALF_POOL + 1);
    localparam int SWEEP_N   = (POOL_ENTRIES > BUCKETS) ? POOL_ENTRIES : BUCKETS;
    localparam int CLW       = $clog2(SWEEP_N);
    localparam logic [LW-1:0] EMPTY = LW'(POOL_ENTRIES);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_HEAD_RD, ST_HEAD_WAIT, ST_SEARCH, ST_SEARCH_WAIT,
        ST_UNLINK, ST_SW_HEAD, ST_SW_HW, ST_SW_LINK, ST_SW_DONE, ST_PROMOTE, ST_ALLOC,
        ST_ALLOC_WAIT, ST_RESULT
    } state_t;

    state_t                    state_reg, state_next;
    logic [OP_W-1:0]           op_reg, op_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [BW-1:0]             b_reg, b_next;
    logic [LW-1:0]             cur_reg, cur_next;
    logic [LW-1:0]             prev_reg, prev_next;
    logic [LW-1:0]             nxt_reg, nxt_next;
    logic [LW-1:0]             yh_reg, yh_next;
    logic [LW-1:0]             oh_reg, oh_next;
    logic                      old_ph_reg, old_ph_next;
    logic                      hit_reg, hit_next;
    logic signed [VALUE_W-1:0] rdval_reg, rdval_next;
    logic                      swapped_reg, swapped_next;
    logic [BW-1:0]             sb_reg, sb_next;
    logic [LW-1:0]             sw_cur_reg, sw_cur_next;
    logic [CLW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                      clr_op_reg, clr_op_next;
    logic                      young_a_reg, young_a_next;
    logic [LW-1:0]             free_reg, free_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [1:0]                swaps_reg, swaps_next;

    logic          at_half;
    logic [LW-1:0] young_head;
    logic [LW-1:0] old_rd_head;

    assign at_half     = fill_reg >= FW'(HALF_POOL);
    // After a swap the young generation is empty, so its heads need no read.
    assign young_head  = swapped_reg ? EMPTY : yh_reg;
    assign old_rd_head = young_a_reg ? h_rd_b : h_rd_a;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        b_next       = b_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        yh_next      = yh_reg;
        oh_next      = oh_reg;
        old_ph_next  = old_ph_reg;
        hit_next     = hit_reg;
        rdval_next   = rdval_reg;
        swapped_next = swapped_reg;
        sb_next      = sb_reg;
        sw_cur_next  = sw_cur_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_op_next  = clr_op_reg;
        young_a_next = young_a_reg;
        free_next    = free_reg;
        fill_next    = fill_reg;
        swaps_next   = swaps_reg;

        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mod_start   = 1'b0;
        e_rd_addr   = cur_reg[IW-1:0];
        e_link_we   = 1'b0;
        e_link_addr = cur_reg[IW-1:0];
        e_link_data = EMPTY;
        e_key_we    = 1'b0;
        e_val_we    = 1'b0;
        e_kv_addr   = cur_reg[IW-1:0];
        e_wr_key    = key_reg;
        e_wr_value  = val_reg;
        h_rd_addr   = b_reg;
        h_we_a      = 1'b0;
        h_we_b      = 1'b0;
        h_wr_addr   = b_reg;
        h_wr_data   = EMPTY;

        case (state_reg)
            ST_CLEAR: begin
                if (int'(clr_cnt_reg) < POOL_ENTRIES) begin
                    e_link_we   = 1'b1;
                    e_link_addr = IW'(clr_cnt_reg);
                    e_link_data = LW'(int'(clr_cnt_reg) + 1);
                end
                if (int'(clr_cnt_reg) < BUCKETS) begin
                    h_we_a    = 1'b1;
                    h_we_b    = 1'b1;
                    h_wr_addr = BW'(clr_cnt_reg);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLW'(SWEEP_N - 1)) begin
                    state_next = clr_op_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next      = in_op;
                    key_next     = in_key;
                    val_next     = in_value;
                    hit_next     = 1'b0;
                    rdval_next   = '0;
                    swapped_next = 1'b0;
                    case (in_op)
                        OP_LOOKUP, OP_STORE: begin
                            mod_start  = 1'b1;
                            state_next = ST_MOD;
                        end
                        OP_CLEAR: begin
                            clr_cnt_next = '0;
                            clr_op_next  = 1'b1;
                            young_a_next = 1'b1;
                            free_next    = '0;
                            fill_next    = '0;
                            swaps_next   = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    b_next     = mod_bucket;
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
                yh_next     = young_a_reg ? h_rd_a : h_rd_b;
                oh_next     = old_rd_head;
                cur_next    = young_a_reg ? h_rd_a : h_rd_b;
                prev_next   = EMPTY;
                old_ph_next = 1'b0;
                state_next  = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (cur_reg != EMPTY) begin
                    state_next = ST_SEARCH_WAIT;
                end else if (!old_ph_reg) begin
                    cur_next    = oh_reg;
                    prev_next   = EMPTY;
                    old_ph_next = 1'b1;
                end else if (at_half) begin
                    state_next = ST_SW_HEAD;
                end else begin
                    state_next = (op_reg == OP_STORE) ? ST_ALLOC : ST_RESULT;
                end
            end
            ST_SEARCH_WAIT: begin
                if (e_rd_key == key_reg) begin
                    hit_next   = 1'b1;
                    rdval_next = e_rd_value;
                    e_val_we   = (op_reg == OP_STORE);
                    if (old_ph_reg) begin
                        nxt_next   = e_rd_link;
                        state_next = ST_UNLINK;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next  = e_rd_link;
                    if (e_rd_link != EMPTY) begin
                        e_rd_addr = e_rd_link[IW-1:0];
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_UNLINK: begin
                if (prev_reg != EMPTY) begin
                    e_link_we   = 1'b1;
                    e_link_addr = prev_reg[IW-1:0];
                    e_link_data = nxt_reg;
                end else begin
                    h_we_a    = !young_a_reg;
                    h_we_b    = young_a_reg;
                    h_wr_data = nxt_reg;
                end
                state_next = at_half ? ST_SW_HEAD : ST_PROMOTE;
            end
            ST_SW_HEAD: begin
                h_rd_addr  = '0;
                sb_next    = '0;
                state_next = ST_SW_HW;
            end
            ST_SW_HW: begin
                h_we_a    = !young_a_reg;
                h_we_b    = young_a_reg;
                h_wr_addr = sb_reg;
                if (old_rd_head != EMPTY) begin
                    sw_cur_next = old_rd_head;
                    e_rd_addr   = old_rd_head[IW-1:0];
                    state_next  = ST_SW_LINK;
                end else if (sb_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_SW_DONE;
                end else begin
                    sb_next   = sb_reg + 1'b1;
                    h_rd_addr = sb_reg + 1'b1;
                end
            end
            ST_SW_LINK: begin
                e_link_we   = 1'b1;
                e_link_addr = sw_cur_reg[IW-1:0];
                e_link_data = free_reg;
                free_next   = sw_cur_reg;
                if (e_rd_link != EMPTY) begin
                    sw_cur_next = e_rd_link;
                    e_rd_addr   = e_rd_link[IW-1:0];
                end else if (sb_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_SW_DONE;
                end else begin
                    sb_next    = sb_reg + 1'b1;
                    h_rd_addr  = sb_reg + 1'b1;
                    state_next = ST_SW_HW;
                end
            end
            ST_SW_DONE: begin
                young_a_next = !young_a_reg;
                fill_next    = '0;
                swapped_next = 1'b1;
                if (swaps_reg != 2'd2) begin
                    swaps_next = swaps_reg + 1'b1;
                end
                if (hit_reg) begin
                    state_next = ST_PROMOTE;
                end else begin
                    state_next = (op_reg == OP_STORE) ? ST_ALLOC : ST_RESULT;
                end
            end
            ST_PROMOTE: begin
                e_link_we   = 1'b1;
                e_link_data = young_head;
                h_we_a      = young_a_reg;
                h_we_b      = !young_a_reg;
                h_wr_data   = cur_reg;
                fill_next   = fill_reg + 1'b1;
                state_next  = ST_RESULT;
            end
            ST_ALLOC: begin
                e_rd_addr  = free_reg[IW-1:0];
                state_next = (free_reg != EMPTY) ? ST_ALLOC_WAIT : ST_RESULT;
            end
            ST_ALLOC_WAIT: begin
                e_key_we    = 1'b1;
                e_val_we    = 1'b1;
                e_kv_addr   = free_reg[IW-1:0];
                e_link_we   = 1'b1;
                e_link_addr = free_reg[IW-1:0];
                e_link_data = young_head;
                h_we_a      = young_a_reg;
                h_we_b      = !young_a_reg;
                h_wr_data   = free_reg;
                free_next   = e_rd_link;
                fill_next   = fill_reg + 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    clr_op_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.hit         = hit_reg;
    assign res.read_value  = hit_reg ? rdval_reg : '0;
    assign res.young_count = COUNT_W'(fill_reg);
    assign res.full_res    = swaps_reg > 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            young_a_reg <= 1'b1;
            free_reg    <= '0;
            fill_reg    <= '0;
            swaps_reg   <= '0;
            hit_reg     <= 1'b0;
            swapped_reg <= 1'b0;
            old_ph_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            young_a_reg <= young_a_next;
            free_reg    <= free_next;
            fill_reg    <= fill_next;
            swaps_reg   <= swaps_next;
            hit_reg     <= hit_next;
            swapped_reg <= swapped_next;
            old_ph_reg  <= old_ph_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        yh_reg     <= yh_next;
        oh_reg     <= oh_next;
        rdval_reg  <= rdval_next;
        sb_reg     <= sb_next;
        sw_cur_reg <= sw_cur_next;
    end

    `TGHC_CHECK(a_fill_bounded, aclk, aresetn, fill_reg <= FW'(HALF_POOL))
    `TGHC_CHECK(a_swaps_saturate, aclk, aresetn, swaps_reg <= 2'd2)
    `TGHC_IMPLY(a_free_walk_valid, aclk, aresetn, state_reg == ST_SW_LINK, sw_cur_reg != EMPTY)
    `TGHC_IMPLY(a_alloc_has_free, aclk, aresetn, state_reg == ST_ALLOC_WAIT, free_reg != EMPTY)

endmodule

>>> sim/cache_checker.sv
`timescale 1ns / 1ps

module cache_checker
    import tghc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending_results
);
    localparam int POOL = DEF_POOL_ENTRIES;
    localparam int NBKT = DEF_BUCKETS;
    localparam int NIL  = POOL;
    localparam int HALF = POOL / 2;

    logic [KEY_W-1:0]   slot_key [POOL];
    logic [VALUE_W-1:0] slot_val [POOL];
    int                 slot_next [POOL];
    int                 head_a [NBKT];
    int                 head_b [NBKT];
    bit                 young_a;
    int                 free_top;
    int                 young_cnt;
    int                 swaps;
    res_t               expected_results[$];

    function automatic void clear_cache();
        for (int i = 0; i < POOL; i++) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_next[i] = i + 1;
        end
        for (int i = 0; i < NBKT; i++) begin
            head_a[i] = NIL;
            head_b[i] = NIL;
        end
        young_a = 1;
        free_top = 0;
        young_cnt = 0;
        swaps = 0;
    endfunction

    function automatic int get_head(bit young, int b);
        return (young == young_a) ? head_a[b] : head_b[b];
    endfunction

    function automatic void set_head(bit young, int b, int v);
        if (young == young_a) head_a[b] = v;
        else head_b[b] = v;
    endfunction

    function automatic int find_in(bit young, int b, logic [KEY_W-1:0] k, output int prev);
        int cur;
        int steps;
        cur = get_head(young, b);
        steps = 0;
        prev = NIL;
        while (cur < NIL && steps < POOL) begin
            if (slot_key[cur] == k) return cur;
            prev = cur;
            cur = slot_next[cur];
            steps++;
        end
        return NIL;
    endfunction

    // The old generation is returned to the free list and the roles flip.
    function automatic void swap_gens();
        int e;
        int steps;
        for (int b = 0; b < NBKT; b++) begin
            steps = 0;
            while (get_head(0, b) < NIL && steps < POOL) begin
                e = get_head(0, b);
                set_head(0, b, slot_next[e]);
                slot_next[e] = free_top;
                free_top = e;
                steps++;
            end
            set_head(0, b, NIL);
        end
        young_a = !young_a;
        young_cnt = 0;
        if (swaps < 2) swaps++;
    endfunction

    function automatic int find_promote(logic [KEY_W-1:0] k, int b);
        int prev;
        int e;
        e = find_in(1, b, k, prev);
        if (e < NIL) return e;
        e = find_in(0, b, k, prev);
        if (e < NIL) begin
            if (prev < NIL) slot_next[prev] = slot_next[e];
            else set_head(0, b, slot_next[e]);
            if (young_cnt >= HALF) swap_gens();
            slot_next[e] = get_head(1, b);
            set_head(1, b, e);
            young_cnt++;
            return e;
        end
        if (young_cnt >= HALF) swap_gens();
        return NIL;
    endfunction

    function automatic res_t cache_step(logic [1:0] op, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
        res_t r;
        int b;
        int e;
        r = '0;
        b = int'(k) % NBKT;
        if (op == OP_LOOKUP || op == OP_STORE) begin
            e = find_promote(k, b);
            if (e < NIL) begin
                r.hit = 1;
                r.read_value = slot_val[e];
                if (op == OP_STORE) slot_val[e] = v;
            end else if (op == OP_STORE && free_top < NIL) begin
                e = free_top;
                slot_key[e] = k;
                slot_val[e] = v;
                free_top = slot_next[e];
                slot_next[e] = get_head(1, b);
                set_head(1, b, e);
                young_cnt++;
            end
        end else if (op == OP_CLEAR) begin
            clear_cache();
        end
        r.young_count = young_cnt[COUNT_W-1:0];
        r.full_res = swaps > 1;
        return r;
    endfunction

    assign pending_results = expected_results.size();

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            clear_cache();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(cache_step(s_tuser, s_tdata[20:0], s_tdata[36:21]));
            if (m_tvalid && m_tready) begin
                got.hit = m_tuser;
                got.read_value = m_tdata[15:0];
                got.young_count = m_tdata[24:16];
                got.full_res = m_tdata[25];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %p, actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tghc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending_results;
    int          idle_cycles = 0;
    bit          hold_off = 0;
    bit          no_stall = 0;
    logic [KEY_W-1:0] key_pool[$];

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    two_generation_hashed_cache dut (.*);

    cache_checker checker_i (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 0;
        else if (no_stall) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 9) < 7);
    end

    task automatic send(input logic [1:0] op, input logic [KEY_W-1:0] k,
                        input logic [VALUE_W-1:0] v);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {3'b0, v, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pause_sender();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 1114111))
                                       : KEY_W'($urandom_range(0, 1023));
        key_pool.push_back(k);
        return k;
    endfunction

    task automatic random_burst(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) send(OP_LOOKUP, pick_key(), 16'($urandom));
            else if (r < 98) send(OP_STORE, pick_key(), 16'($urandom));
            else if (r < 99) send(OP_CLEAR, pick_key(), 16'($urandom));
            else send(OP_UNUSED, pick_key(), 16'($urandom));
            if ($urandom_range(0, 3) == 0) pause_sender();
        end
    endtask

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: extremes, chains in one bucket, every op, odd op code.
        send(OP_LOOKUP, 21'd0, 16'h0000);
        send(OP_STORE, 21'd0, 16'h7FFF);
        send(OP_STORE, 21'd1114111, 16'h8000);
        send(OP_STORE, 21'h1FFFFF, 16'hFFFF);
        send(OP_STORE, 21'd64, 16'h1234);
        send(OP_STORE, 21'd128, 16'h5555);
        send(OP_LOOKUP, 21'd0, 16'h0);
        send(OP_LOOKUP, 21'd64, 16'h0);
        send(OP_LOOKUP, 21'd1114111, 16'h0);
        send(OP_STORE, 21'd64, 16'hAAAA);
        send(OP_LOOKUP, 21'd192, 16'hFFFF);
        send(OP_UNUSED, 21'h1FFFFF, 16'hFFFF);
        send(OP_CLEAR, 21'h1FFFFF, 16'hFFFF);
        send(OP_LOOKUP, 21'd0, 16'h0);
        send(OP_STORE, 21'h155555, 16'h5A5A);
        send(OP_LOOKUP, 21'h0AAAAA, 16'h0);

        // Fill the young generation to force a swap, with a long receiver hold-off.
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 300; i++) send(OP_STORE, KEY_W'(i * 7), 16'($urandom));
        join
        s_tvalid <= 0;
        for (int i = 0; i < 300; i += 3) send(OP_LOOKUP, KEY_W'(i * 7), 16'($urandom));
        sent = 16 + 300 + 100;

        while (sent < 1050) begin
            no_stall = ($urandom_range(0, 4) == 0);
            n = $urandom_range(1, 30);
            random_burst(n);
            sent += n;
            if (key_pool.size() > 400) key_pool.delete();
            pause_sender();
        end
        s_tvalid <= 0;
        no_stall = 0;

        while (pending_results != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
